FILE: hdl/sac_pkg.sv
// Shared types and constants of the session admission control block.
// No dependencies; every other file but sac_if imports it.
`default_nettype none
package sac_pkg;

	localparam int STORE_DEPTH_DEF   = 256;
	localparam int SESSION_COUNT_DEF = 256;

	localparam logic [31:0] WINDOW_RST = 32'd1000;
	localparam logic [31:0] PERIOD_RST = 32'd100;
	localparam logic [23:0] TARGET_RST = 24'd65536;
	localparam logic [23:0] MAX_RST    = 24'd131072;

	localparam logic [7:0] REG_WINDOW_TICKS  = 8'd0;
	localparam logic [7:0] REG_SAMPLE_PERIOD = 8'd1;
	localparam logic [7:0] REG_TARGET_BYTES  = 8'd2;
	localparam logic [7:0] REG_MAX_BYTES     = 8'd3;

	typedef struct packed {
		logic clr_step;
		logic latch_in;
		logic resample;
		logic rec_rd;
		logic pop;
		logic sess_dec;
		logic snap;
		logic under;
		logic set_flag;
		logic scan_start;
		logic scan_step;
		logic apply_blk;
		logic push_wr;
		logic push_upd;
		logic mark_ovf;
		logic mark_acc;
		logic out_load;
	} sac_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic sample_due;
		logic count_zero;
		logic rec_old;
		logic sum_under;
		logic sum_under_max;
		logic period_flag;
		logic scan_done;
		logic sid_blocked;
		logic store_full;
		logic out_free;
	} sac_sts_t;

endpackage
`default_nettype wire

FILE: hdl/sac_if.sv
// Channel interfaces: packet input, admission result and configuration write.
// No dependencies.
`default_nettype none
interface sac_pkt_if;
	logic        valid;
	logic        ready;
	logic [31:0] arrival_time;
	logic [7:0]  session_id;
	logic [15:0] byte_length;
	modport source (output valid, arrival_time, session_id, byte_length, input ready);
	modport sink   (input valid, arrival_time, session_id, byte_length, output ready);
endinterface

interface sac_res_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        store_overflow;
	logic [31:0] rejected_sessions;
	logic [31:0] total_sessions;
	modport source (output valid, accepted, store_overflow, rejected_sessions,
		total_sessions, input ready);
	modport sink   (input valid, accepted, store_overflow, rejected_sessions,
		total_sessions, output ready);
endinterface

interface sac_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/sac_ctrl.sv
// Sequencer of the admission block: steps one item through prune, decide, scan and store.
// Depends on sac_pkg.
`default_nettype none
module sac_ctrl import sac_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pkt_valid,
	output logic          pkt_ready,
	input  wire sac_sts_t sts,
	output sac_cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_PRUNE_RD, S_PRUNE_CHK, S_PRUNE_UPD, S_SNAP,
		S_DECIDE, S_SCAN, S_APPLY, S_CHECK_BLK, S_PUSH, S_DROP_CHK, S_DROP_UPD,
		S_PUSH_WR, S_PUSH_UPD, S_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_d = S_IDLE;
				else cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				if (pkt_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.sample_due) begin
					cmd.resample = 1'b1;
					state_d      = S_PRUNE_RD;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_PRUNE_RD: begin
				if (sts.count_zero) state_d = S_SNAP;
				else begin
					cmd.rec_rd = 1'b1;
					state_d    = S_PRUNE_CHK;
				end
			end
			S_PRUNE_CHK: begin
				if (sts.rec_old) begin
					cmd.pop = 1'b1;
					state_d = S_PRUNE_UPD;
				end else begin
					state_d = S_SNAP;
				end
			end
			S_PRUNE_UPD: begin
				cmd.sess_dec = 1'b1;
				state_d      = S_PRUNE_RD;
			end
			S_SNAP: begin
				cmd.snap = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.sum_under) begin
					cmd.under    = 1'b1;
					cmd.mark_acc = 1'b1;
					state_d      = S_PUSH;
				end else if (sts.sum_under_max) begin
					if (!sts.period_flag) begin
						cmd.set_flag   = 1'b1;
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end else begin
						state_d = S_CHECK_BLK;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_APPLY;
				else cmd.scan_step = 1'b1;
			end
			S_APPLY: begin
				cmd.apply_blk = 1'b1;
				state_d       = S_CHECK_BLK;
			end
			S_CHECK_BLK: begin
				if (sts.sid_blocked) state_d = S_FINISH;
				else begin
					cmd.mark_acc = 1'b1;
					state_d      = S_PUSH;
				end
			end
			S_PUSH: begin
				if (sts.store_full) begin
					cmd.mark_ovf = 1'b1;
					cmd.rec_rd   = 1'b1;
					state_d      = S_DROP_CHK;
				end else begin
					state_d = S_PUSH_WR;
				end
			end
			S_DROP_CHK: begin
				cmd.pop = 1'b1;
				state_d = S_DROP_UPD;
			end
			S_DROP_UPD: begin
				cmd.sess_dec = 1'b1;
				state_d      = S_PUSH_WR;
			end
			S_PUSH_WR: begin
				cmd.push_wr = 1'b1;
				state_d     = S_PUSH_UPD;
			end
			S_PUSH_UPD: begin
				cmd.push_upd = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	assign pkt_ready = (state_q == S_IDLE);

endmodule
`default_nettype wire

FILE: hdl/sac_dp.sv
// Datapath: configuration registers, record ring, per-session totals, maps, scan and result register.
// Depends on sac_pkg.
`default_nettype none
module sac_dp import sac_pkg::*; #(
	parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
	parameter int SESSION_COUNT = SESSION_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sac_cmd_t    cmd,
	output sac_sts_t         sts,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic [31:0] arrival_time,
	input  wire logic [7:0]  session_id,
	input  wire logic [15:0] byte_length,
	input  wire logic        res_ready,
	output logic             res_valid,
	output logic             accepted,
	output logic             store_overflow,
	output logic [31:0]      rejected_sessions,
	output logic [31:0]      total_sessions
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int LW = AW + 16;
	localparam int SW = $clog2(SESSION_COUNT);
	localparam int NW = $clog2(SESSION_COUNT + 1);
	localparam int EW = CW + LW;
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(STORE_DEPTH);
	localparam logic [AW-1:0] LAST_C  = AW'(STORE_DEPTH - 1);
	localparam logic [NW-1:0] SCNT_C  = NW'(SESSION_COUNT);

	logic [31:0] window_q, period_q;
	logic [23:0] target_q, max_q;
	logic [31:0] now_q, last_q, wsum_q;
	logic [7:0]  sid8_q;
	logic [SW-1:0] sid_q;
	logic [15:0] len_q;
	logic [SW-1:0] sid_lut [256];

	logic [55:0] rec_mem [STORE_DEPTH];
	logic [55:0] rec_q;
	logic [EW-1:0] sess_mem [SESSION_COUNT];
	logic [EW-1:0] sess_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] total_q;
	logic [SW-1:0] pop_sid_q;
	logic [15:0]   pop_len_q;

	logic [SESSION_COUNT-1:0] present_q, active_q, blocked_q;
	logic flag_q, acc_q, ovf_q;
	logic [31:0] rej_cnt_q, ses_cnt_q;
	logic [NW-1:0] clr_idx_q, scan_idx_q;
	logic [SW-1:0] idx_s1, pick_q;
	logic vld_s1, found_q;
	logic [LW-1:0] best_q;

	logic [SW-1:0] rec_sid;
	logic [AW:0]   wr_sum;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] sess_cnt;
	logic [LW-1:0] sess_load;
	logic scan_issue, sess_rd;
	logic [SW-1:0] rd_addr;

	genvar g;
	generate
		for (g = 0; g < 256; g++) begin : g_lut
			assign sid_lut[g] = SW'(g % SESSION_COUNT);
		end
	endgenerate

	assign rec_sid   = sid_lut[rec_q[23:16]];
	assign wr_sum    = {1'b0, head_q} + (AW+1)'(count_q);
	assign wr_addr   = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : wr_sum[AW-1:0];
	assign sess_cnt  = sess_q[EW-1:LW];
	assign sess_load = sess_q[LW-1:0];
	assign scan_issue = cmd.scan_step && (scan_idx_q < SCNT_C);
	assign sess_rd   = cmd.pop || cmd.push_wr || scan_issue;

	always_comb begin
		if (scan_issue) rd_addr = scan_idx_q[SW-1:0];
		else if (cmd.pop) rd_addr = rec_sid;
		else rd_addr = sid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			period_q <= PERIOD_RST;
			target_q <= TARGET_RST;
			max_q    <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_TICKS:  window_q <= cfg_data;
				REG_SAMPLE_PERIOD: period_q <= cfg_data;
				REG_TARGET_BYTES:  target_q <= cfg_data[23:0];
				REG_MAX_BYTES:     max_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			now_q  <= arrival_time;
			sid8_q <= session_id;
			sid_q  <= sid_lut[session_id];
			len_q  <= byte_length;
		end
		if (cmd.rec_rd) rec_q <= rec_mem[head_q];
		if (cmd.push_wr) rec_mem[wr_addr] <= {now_q, sid8_q, len_q};
		if (sess_rd) sess_q <= sess_mem[rd_addr];
		if (cmd.clr_step) sess_mem[clr_idx_q[SW-1:0]] <= '0;
		else if (cmd.sess_dec)
			sess_mem[pop_sid_q] <= {sess_cnt - CW'(1), sess_load - LW'(pop_len_q)};
		else if (cmd.push_upd)
			sess_mem[sid_q] <= {sess_cnt + CW'(1), sess_load + LW'(len_q)};
		if (cmd.pop) begin
			pop_sid_q <= rec_sid;
			pop_len_q <= rec_q[15:0];
		end
		if (scan_issue) idx_s1 <= scan_idx_q[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			total_q    <= '0;
			wsum_q     <= '0;
			last_q     <= '0;
			flag_q     <= 1'b0;
			present_q  <= '0;
			active_q   <= '0;
			blocked_q  <= '0;
			rej_cnt_q  <= '0;
			ses_cnt_q  <= '0;
			clr_idx_q  <= '0;
			scan_idx_q <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			best_q     <= '0;
			pick_q     <= '0;
			acc_q      <= 1'b0;
			ovf_q      <= 1'b0;
			res_valid  <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_idx_q <= clr_idx_q + NW'(1);
			if (cmd.latch_in) begin
				acc_q <= 1'b0;
				ovf_q <= 1'b0;
			end
			if (cmd.mark_acc) acc_q <= 1'b1;
			if (cmd.mark_ovf) ovf_q <= 1'b1;
			if (cmd.resample) begin
				last_q <= now_q;
				flag_q <= 1'b0;
			end
			if (cmd.pop) begin
				head_q  <= (head_q == LAST_C) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
				total_q <= total_q - LW'(rec_q[15:0]);
			end
			if (cmd.sess_dec && sess_cnt == CW'(1)) present_q[pop_sid_q] <= 1'b0;
			if (cmd.snap) begin
				wsum_q   <= 32'(total_q);
				active_q <= present_q;
			end
			if (cmd.under) begin
				blocked_q <= '0;
				if (!active_q[sid_q] && ses_cnt_q != '1) ses_cnt_q <= ses_cnt_q + 32'd1;
			end
			if (cmd.set_flag) flag_q <= 1'b1;
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				vld_s1     <= 1'b0;
				found_q    <= 1'b0;
				best_q     <= '0;
			end else if (cmd.scan_step) begin
				vld_s1 <= scan_issue;
				if (scan_issue) scan_idx_q <= scan_idx_q + NW'(1);
			end
			if (vld_s1 && active_q[idx_s1] && sess_load > best_q) begin
				best_q  <= sess_load;
				pick_q  <= idx_s1;
				found_q <= 1'b1;
			end
			if (cmd.apply_blk && found_q) begin
				if (!blocked_q[pick_q] && rej_cnt_q != '1) rej_cnt_q <= rej_cnt_q + 32'd1;
				blocked_q[pick_q] <= 1'b1;
				active_q[pick_q]  <= 1'b0;
			end
			if (cmd.push_wr) begin
				count_q <= count_q + CW'(1);
				total_q <= total_q + LW'(len_q);
			end
			if (cmd.push_upd) begin
				present_q[sid_q] <= 1'b1;
				active_q[sid_q]  <= 1'b1;
			end
			if (cmd.out_load) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			accepted          <= acc_q;
			store_overflow    <= ovf_q;
			rejected_sessions <= rej_cnt_q;
			total_sessions    <= ses_cnt_q;
		end
	end

	always_comb begin
		sts.clr_done      = (clr_idx_q == SCNT_C);
		sts.sample_due    = {1'b0, now_q} >= ({1'b0, last_q} + {1'b0, period_q});
		sts.count_zero    = (count_q == '0);
		sts.rec_old       = ({1'b0, rec_q[55:24]} + {1'b0, window_q}) < {1'b0, now_q};
		sts.sum_under     = wsum_q < {8'd0, target_q};
		sts.sum_under_max = wsum_q < {8'd0, max_q};
		sts.period_flag   = flag_q;
		sts.scan_done     = (scan_idx_q == SCNT_C) && !vld_s1;
		sts.sid_blocked   = blocked_q[sid_q];
		sts.store_full    = (count_q == DEPTH_C);
		sts.out_free      = !res_valid || res_ready;
	end

endmodule
`default_nettype wire

FILE: hdl/session_admission_control.sv
// Top level of the session admission control block: sequencer plus datapath.
// Depends on sac_pkg, sac_if, sac_ctrl, sac_dp.
//
//   channel  dir  handshake     payload
//   pkt      in   valid/ready   arrival_time, session_id, byte_length
//   res      out  valid/ready   accepted, store_overflow, rejected_sessions, total_sessions
//   cfg      in   valid/ready   index, data (always ready)
//
// An item is taken only when the previous one is finished: the sequencer steps it through
// the decision and, when admitted, a store write and a per-session totals update. A full
// store adds the drop of the oldest record, a resample adds a prune step per dropped record
// and a snapshot, and the once-per-period heaviest-session search adds a read of every
// session's totals, all serialised by the single-port per-session totals memory. After reset
// the totals memory is cleared entry by entry with pkt.ready low. A stalled result holds in
// the output register while the next item is taken.
`default_nettype none
module session_admission_control import sac_pkg::*; #(
	parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
	parameter int SESSION_COUNT = SESSION_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sac_cfg_if.sink  cfg,
	sac_pkt_if.sink  pkt,
	sac_res_if.source res
);

	sac_cmd_t cmd;
	sac_sts_t sts;

	assign cfg.ready = 1'b1;

	sac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.pkt_ready (pkt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sac_dp #(
		.STORE_DEPTH   (STORE_DEPTH),
		.SESSION_COUNT (SESSION_COUNT)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.arrival_time      (pkt.arrival_time),
		.session_id        (pkt.session_id),
		.byte_length       (pkt.byte_length),
		.res_ready         (res.ready),
		.res_valid         (res.valid),
		.accepted          (res.accepted),
		.store_overflow    (res.store_overflow),
		.rejected_sessions (res.rejected_sessions),
		.total_sessions    (res.total_sessions)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("result loaded over a pending item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt.valid && pkt.ready) |=> !pkt.ready) else $error("ready held after accept");

	a_pop_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.pop && cmd.push_wr)) else $error("pop and push in one cycle");

	a_full_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sts.store_full |-> !sts.count_zero) else $error("store full and empty");

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench for session_admission_control: directed packets, then random phases
// under several register settings, checked against an in-bench admission predictor.
// Depends on hdl/sac_pkg.sv, hdl/sac_if.sv and the block's RTL.
`timescale 1ns / 1ps
module testbench;
	import sac_pkg::*;

	localparam int DEPTH = 256;
	localparam int SESS = 256;
	localparam int IDLE_LIMIT = 6000;

	typedef struct packed {
		logic        acc;
		logic        ovf;
		logic [31:0] rej;
		logic [31:0] tot;
	} verdict_t;

	typedef struct packed {
		logic [31:0] t;
		logic [7:0]  sid;
		logic [15:0] len;
		logic        typed;
		verdict_t    want;
	} pkt_row_t;

	logic clk = 0;
	logic arst_n = 0;
	sac_cfg_if cfg();
	sac_pkt_if pkt();
	sac_res_if res();

	session_admission_control i_dut (.clk(clk), .arst_n(arst_n), .cfg(cfg), .pkt(pkt), .res(res));

	always #6 clk = ~clk;

	// predictor state
	logic [31:0] m_window, m_period, m_target, m_max;
	logic [31:0] s_time [DEPTH];
	logic [7:0]  s_sid [DEPTH];
	logic [15:0] s_len [DEPTH];
	int          s_head, s_cnt;
	logic [31:0] load_sum, last_sample, rej_cnt, sess_cnt;
	logic        active [SESS];
	logic        blocked [SESS];
	logic        period_flag;

	verdict_t verdicts [$];
	int fails = 0, n_pkts = 0, n_acc = 0, n_ovf = 0, idle_cycles = 0;
	bit calm = 0;

	function automatic verdict_t admit(logic [31:0] now, logic [7:0] sid, logic [15:0] len);
		verdict_t v;
		longint sum;
		longint weight [SESS];
		longint best;
		int pick, s;
		bit found;
		v = '0;
		if (longint'(now) >= longint'(last_sample) + longint'(m_period)) begin
			period_flag = 0;
			while (s_cnt > 0 && longint'(s_time[s_head]) + longint'(m_window) < longint'(now)) begin
				s_head = (s_head + 1) % DEPTH;
				s_cnt--;
			end
			for (int i = 0; i < SESS; i++) active[i] = 0;
			sum = 0;
			for (int k = 0; k < s_cnt; k++) begin
				s = (s_head + k) % DEPTH;
				sum += s_len[s];
				active[s_sid[s]] = 1;
			end
			load_sum = sum > 64'hFFFFFFFF ? 32'hFFFFFFFF : sum[31:0];
			last_sample = now;
		end
		if (load_sum < m_target) begin
			for (int i = 0; i < SESS; i++) blocked[i] = 0;
			if (!active[sid] && sess_cnt != '1) sess_cnt++;
			v.acc = 1;
		end else if (load_sum < m_max) begin
			if (!period_flag) begin
				period_flag = 1;
				for (int i = 0; i < SESS; i++) weight[i] = 0;
				for (int k = 0; k < s_cnt; k++) begin
					s = (s_head + k) % DEPTH;
					weight[s_sid[s]] += s_len[s];
				end
				best = 0; pick = 0; found = 0;
				for (int i = 0; i < SESS; i++)
					if (active[i] && weight[i] > best) begin
						best = weight[i]; pick = i; found = 1;
					end
				if (found) begin
					if (!blocked[pick]) begin
						if (rej_cnt != '1) rej_cnt++;
						blocked[pick] = 1;
					end
					active[pick] = 0;
				end
			end
			v.acc = !blocked[sid];
		end
		if (v.acc) begin
			if (s_cnt >= DEPTH) begin
				s_head = (s_head + 1) % DEPTH;
				s_cnt = DEPTH - 1;
				v.ovf = 1;
			end
			s = (s_head + s_cnt) % DEPTH;
			s_time[s] = now; s_sid[s] = sid; s_len[s] = len;
			s_cnt++;
			active[sid] = 1;
		end
		v.rej = rej_cnt;
		v.tot = sess_cnt;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (calm || r < 5) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send(logic [31:0] t, logic [7:0] sid, logic [15:0] len, bit typed,
			verdict_t want);
		int gap;
		verdict_t v;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) pkt.valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pkt.valid <= 1;
		pkt.arrival_time <= t;
		pkt.session_id <= sid;
		pkt.byte_length <= len;
		do @(posedge clk); while (!pkt.ready);
		v = admit(t, sid, len);
		if (typed && v != want) begin
			$display("%0t table row mismatch: expected %h actual predictor %h", $time, want, v);
			fails++;
		end
		verdicts.insert(verdicts.size(), v);
		n_pkts++;
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] data);
		@(negedge clk);
		pkt.valid <= 0;
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_WINDOW_TICKS:  m_window = data;
			REG_SAMPLE_PERIOD: m_period = data;
			REG_TARGET_BYTES:  m_target = {8'd0, data[23:0]};
			REG_MAX_BYTES:     m_max = {8'd0, data[23:0]};
			default: ;
		endcase
		@(negedge clk) cfg.valid <= 0;
	endtask

	task automatic drain();
		@(negedge clk) pkt.valid <= 0;
		while (verdicts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_phase(logic [31:0] win, logic [31:0] per, logic [23:0] tgt,
			logic [23:0] mx, int n, int step, int sid_hi, int len_hi, inout logic [31:0] now);
		drain();
		write_reg(REG_WINDOW_TICKS, win);
		write_reg(REG_SAMPLE_PERIOD, per);
		write_reg(REG_TARGET_BYTES, {8'd0, tgt});
		write_reg(REG_MAX_BYTES, {8'd0, mx});
		calm = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < n; i++) begin
			if (now > 32'hFFFFFFFF - step) now = 32'hFFFFFFFF;
			else now += $urandom_range(0, step);
			send(now, 8'($urandom_range(0, sid_hi)),
				16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, len_hi)),
				0, '0);
		end
	endtask

	// result side
	int stall = 0;
	always @(negedge clk) begin
		if (stall > 0) begin
			res.ready <= 0;
			stall--;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			res.ready <= 0;
		end else
			res.ready <= 1;
	end

	always @(posedge clk) begin
		verdict_t got, exp_v;
		if (res.valid && res.ready) begin
			got = {res.accepted, res.store_overflow, res.rejected_sessions, res.total_sessions};
			if (verdicts.size() == 0) begin
				$display("%0t unexpected result: actual %h", $time, got);
				fails++;
			end else begin
				exp_v = verdicts[0];
				verdicts.delete(0);
				if (got.acc !== exp_v.acc) begin
					$display("%0t accepted: expected %b actual %b", $time, exp_v.acc, got.acc);
					fails++;
				end
				if (got.ovf !== exp_v.ovf) begin
					$display("%0t store_overflow: expected %b actual %b", $time, exp_v.ovf, got.ovf);
					fails++;
				end
				if (got.rej !== exp_v.rej) begin
					$display("%0t rejected_sessions: expected %0d actual %0d", $time, exp_v.rej, got.rej);
					fails++;
				end
				if (got.tot !== exp_v.tot) begin
					$display("%0t total_sessions: expected %0d actual %0d", $time, exp_v.tot, got.tot);
					fails++;
				end
				n_acc += got.acc;
				n_ovf += got.ovf;
			end
		end
	end

	always @(posedge clk) begin
		if ((pkt.valid && pkt.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t watchdog: no progress, %0d results outstanding", $time, verdicts.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	pkt_row_t rows [12];
	logic [31:0] now;

	initial begin
		pkt.valid = 0; pkt.arrival_time = 0; pkt.session_id = 0; pkt.byte_length = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		res.ready = 0;
		m_window = WINDOW_RST; m_period = PERIOD_RST;
		m_target = {8'd0, TARGET_RST}; m_max = {8'd0, MAX_RST};
		s_head = 0; s_cnt = 0; load_sum = 0; last_sample = 0;
		rej_cnt = 0; sess_cnt = 0; period_flag = 0;
		for (int i = 0; i < SESS; i++) begin
			active[i] = 0; blocked[i] = 0;
		end
		rows = '{
			'{32'd0,   8'd0,   16'd0,     1'b1, '{1'b1, 1'b0, 32'd0, 32'd1}},
			'{32'd5,   8'd255, 16'd65535, 1'b1, '{1'b1, 1'b0, 32'd0, 32'd2}},
			'{32'd10,  8'd255, 16'd65535, 1'b1, '{1'b1, 1'b0, 32'd0, 32'd2}},
			'{32'd200, 8'd7,   16'd100,   1'b0, '0},
			'{32'd201, 8'd255, 16'd1,     1'b0, '0},
			'{32'd202, 8'd0,   16'd9,     1'b0, '0},
			'{32'd300, 8'd3,   16'd5,     1'b0, '0},
			'{32'd250, 8'd3,   16'd5,     1'b0, '0},
			'{32'd1500, 8'd128, 16'd32768, 1'b0, '0},
			'{32'd1500, 8'd127, 16'd32767, 1'b0, '0},
			'{32'd1700, 8'd255, 16'd65535, 1'b0, '0},
			'{32'd3000, 8'd1,   16'd1,     1'b0, '0}
		};
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		foreach (rows[i])
			send(rows[i].t, rows[i].sid, rows[i].len, rows[i].typed, rows[i].want);
		now = 32'd3000;
		run_phase(32'd2000, 32'd50, 24'd20000, 24'd60000, 150, 20, 7, 2000, now);
		run_phase(32'd1, 32'd0, 24'd0, 24'd0, 30, 5, 255, 65535, now);
		run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 200, 3, 31, 500, now);
		run_phase(32'd500, 32'd0, 24'd5000, 24'd30000, 120, 10, 5, 3000, now);
		now = 32'hFFFFF000;
		run_phase(32'd300, 32'd40, 24'd40000, 24'hFFFFFF, 100, 40, 255, 4000, now);
		send(32'hFFFFFFFF, 8'hAA, 16'h5555, 0, '0);
		send(32'd77, 8'h55, 16'hAAAA, 0, '0);
		drain();
		$display("%0d packets over six register settings, %0d admitted, %0d store overflows",
			n_pkts, n_acc, n_ovf);
		if (fails == 0 && verdicts.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

FILE: session_admission_control.f
hdl/sac_pkg.sv
hdl/sac_if.sv
hdl/sac_ctrl.sv
hdl/sac_dp.sv
hdl/session_admission_control.sv
test/testbench.sv
